[rtl/core/stl_pkg.sv]
// Shared types, codes and sizes for the sorted timer list.
package stl_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned MAX_REPORT = 16;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned ID_W = 16;
	localparam int unsigned DELAY_W = 20;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_START  = 2'd1,
		REQ_CANCEL = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_EXPIRED   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_TICK,
		S_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // capture the request
		logic scan_step;   // advance scan pointer by one entry
		logic shift_step;  // move one entry one place
		logic commit;      // apply count change, write inserted entry
		logic tick_pop;    // report and drop the head entry
		logic clear;       // empty the list
		logic out_load;    // load the result register
		logic out_last;    // last flag for the loaded result
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;   // scan pointer reached stopping place
		logic found;       // cancel matched at scan pointer
		logic full;        // list holds DEPTH entries
		logic shift_done;  // shifting pass finished
		logic head_expired;
		logic head_more;   // another expired entry behind the head
		logic out_busy;    // result register still occupied
	} dp_stat_t;

endpackage

[rtl/core/stl_datapath.sv]
// Datapath of the sorted timer list: entry registers, scan pointer, tick count and result register.
module stl_datapath #(
	parameter int unsigned DEPTH = stl_pkg::DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [1:0]                req_type,
	input  logic [stl_pkg::ID_W-1:0]  timer_id,
	input  logic [stl_pkg::DELAY_W-1:0] delay_ticks,
	input  stl_pkg::dp_cmd_t          cmd,
	output stl_pkg::dp_stat_t         stat,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                status,
	output logic [stl_pkg::ID_W-1:0]  result_id,
	output logic                      last
);
	import stl_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH + 1);
	localparam int unsigned IW = $clog2(DEPTH);

	logic [TIME_W-1:0] exp_q [DEPTH];
	logic [ID_W-1:0]   ident_q [DEPTH];
	logic [PW-1:0]     count_q;
	logic [PW-1:0]     ptr_q;
	logic [PW-1:0]     sh_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] new_exp_q;
	logic [ID_W-1:0]   id_q;
	logic [1:0]        req_q;
	logic [4:0]        rep_q;
	logic              found_q;
	logic [TIME_W-1:0] diff;
	logic [TIME_W-1:0] head_diff;
	logic [TIME_W-1:0] next_diff;
	logic [IW-1:0]     ptr_idx;
	logic [IW-1:0]     sh_idx;
	logic              ptr_in;
	logic              ins_stop;
	logic              ident_hit;

	assign ptr_idx = ptr_q[IW-1:0];
	assign sh_idx = sh_q[IW-1:0];
	assign ptr_in = ptr_q < count_q;
	assign diff = new_exp_q - exp_q[ptr_idx];
	assign ident_hit = ident_q[ptr_idx] == id_q;
	// Insert stops before the first entry with a later expiry.
	assign ins_stop = diff[TIME_W-1];
	assign head_diff = now_q - exp_q[0];
	assign next_diff = now_q - exp_q[1];

	// Status toward the controller.
	always_comb begin
		stat = '0;
		stat.full = count_q == PW'(DEPTH);
		stat.found = (req_q == REQ_CANCEL) && ptr_in && ident_hit;
		if (req_q == REQ_CANCEL)
			stat.scan_done = !ptr_in || ident_hit;
		else
			stat.scan_done = !ptr_in || ins_stop;
		// Insert shifts down from count; cancel shifts up toward count.
		if (req_q == REQ_START)
			stat.shift_done = sh_q == ptr_q;
		else
			stat.shift_done = sh_q + PW'(1) >= count_q;
		stat.head_expired = (count_q != '0) && !head_diff[TIME_W-1]
			&& (rep_q != 5'(MAX_REPORT));
		stat.head_more = (count_q > PW'(1)) && !next_diff[TIME_W-1]
			&& (rep_q + 5'd1 != 5'(MAX_REPORT));
		stat.out_busy = out_valid;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			now_q <= '0;
			ptr_q <= '0;
			sh_q <= '0;
			found_q <= 1'b0;
			rep_q <= '0;
			req_q <= REQ_TICK;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			if (cmd.load) begin
				req_q <= req_type;
				ptr_q <= '0;
				found_q <= 1'b0;
				rep_q <= '0;
				if (req_type == REQ_TICK)
					now_q <= now_q + TIME_W'(1);
			end
			if (cmd.scan_step) begin
				if (req_q == REQ_CANCEL && ptr_in && ident_hit) begin
					found_q <= 1'b1;
					sh_q <= ptr_q;
				end else if (ptr_in && !(req_q == REQ_START && ins_stop)) begin
					ptr_q <= ptr_q + PW'(1);
				end else begin
					sh_q <= count_q;
				end
			end
			if (cmd.shift_step) begin
				if (req_q == REQ_START)
					sh_q <= sh_q - PW'(1);
				else
					sh_q <= sh_q + PW'(1);
			end
			if (cmd.commit) begin
				if (req_q == REQ_START)
					count_q <= count_q + PW'(1);
				else if (found_q)
					count_q <= count_q - PW'(1);
			end
			if (cmd.tick_pop) begin
				count_q <= count_q - PW'(1);
				rep_q <= rep_q + 5'd1;
			end
			if (cmd.clear)
				count_q <= '0;
			if (cmd.out_load)
				out_valid <= 1'b1;
		end
	end

	// Payload: request capture, entry moves and result register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q <= timer_id;
			new_exp_q <= now_q + TIME_W'(delay_ticks);
		end
		if (cmd.shift_step) begin
			if (req_q == REQ_START) begin
				exp_q[sh_idx] <= exp_q[sh_idx - IW'(1)];
				ident_q[sh_idx] <= ident_q[sh_idx - IW'(1)];
			end else begin
				exp_q[sh_idx] <= exp_q[sh_idx + IW'(1)];
				ident_q[sh_idx] <= ident_q[sh_idx + IW'(1)];
			end
		end
		if (cmd.commit && req_q == REQ_START) begin
			exp_q[ptr_idx] <= new_exp_q;
			ident_q[ptr_idx] <= id_q;
		end
		// Popping the head moves every entry up one place.
		if (cmd.tick_pop) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				exp_q[i] <= exp_q[i + 1];
				ident_q[i] <= ident_q[i + 1];
			end
		end
		if (cmd.out_load) begin
			last <= cmd.out_last;
			unique case (req_q)
				REQ_TICK: begin
					status <= ST_EXPIRED;
					result_id <= ident_q[0];
				end
				REQ_START: begin
					status <= stat.full ? ST_FULL : ST_OK;
					result_id <= id_q;
				end
				REQ_CANCEL: begin
					status <= found_q ? ST_OK : ST_NOT_FOUND;
					result_id <= id_q;
				end
				default: begin
					status <= ST_OK;
					result_id <= '0;
				end
			endcase
		end
	end

endmodule

[rtl/core/stl_ctrl.sv]
// Controller state machine of the sorted timer list.
module stl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        req_type,
	input  stl_pkg::dp_stat_t stat,
	output stl_pkg::dp_cmd_t  cmd
);
	import stl_pkg::*;

	state_t state_q, state_d;
	logic [1:0] req_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q <= REQ_TICK;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready)
				req_q <= req_type;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:
				if (in_valid)
					state_d = (req_type == REQ_TICK) ? S_TICK
						: (req_type == REQ_CLEAR) ? S_EMIT : S_SCAN;
			S_SCAN:
				if (req_q == REQ_START && stat.full)
					state_d = S_EMIT;
				else if (stat.found || stat.scan_done)
					state_d = (req_q == REQ_CANCEL && !stat.found) ? S_EMIT : S_SHIFT;
			S_SHIFT:
				if (stat.shift_done)
					state_d = S_EMIT;
			S_TICK:
				if (!stat.head_expired || !stat.head_more)
					state_d = stat.head_expired ? S_EMIT : S_IDLE;
			S_EMIT:
				if (!stat.out_busy)
					state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_SCAN:
				cmd.scan_step = !(req_q == REQ_START && stat.full);
			S_SHIFT:
				if (!stat.shift_done)
					cmd.shift_step = 1'b1;
			S_TICK:
				if (stat.head_expired && !stat.out_busy && stat.head_more) begin
					cmd.out_load = 1'b1;
					cmd.tick_pop = 1'b1;
				end
			S_EMIT:
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					if (req_q == REQ_TICK)
						cmd.tick_pop = 1'b1;
					else if (req_q == REQ_CLEAR)
						cmd.clear = 1'b1;
					else if (!(req_q == REQ_START && stat.full))
						cmd.commit = 1'b1;
				end
			default: ;
		endcase
	end

endmodule

[rtl/core/sorted_timer_list_unit.sv]
// Sorted timer list: up to DEPTH timers kept in expiry order over a tick count.
// A start scans, shifts and emits; on a full list it goes straight from scan to emit.
// A cancel scans, shifts only if the timer was found, then emits; a clear goes straight to emit.
// A tick returns to idle with nothing expired, else reports each expired entry in turn.
// One request is in work at a time; the result register lets the next request enter.
// Reset empties the list and zeroes the tick count; entry contents stay undefined.
module sorted_timer_list_unit #(
	parameter int unsigned DEPTH = stl_pkg::DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   req_type,
	input  logic [stl_pkg::ID_W-1:0]     timer_id,
	input  logic [stl_pkg::DELAY_W-1:0]  delay_ticks,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic [stl_pkg::ID_W-1:0]     result_id,
	output logic                         last
);
	import stl_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	stl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .stat(stat), .cmd(cmd)
	);

	stl_datapath #(.DEPTH(DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .req_type(req_type), .timer_id(timer_id),
		.delay_ticks(delay_ticks), .cmd(cmd), .stat(stat), .out_valid(out_valid),
		.out_ready(out_ready), .status(status), .result_id(result_id), .last(last)
	);

endmodule
